// File: src/bitmap_id_allocator_defines.svh
// Assertion macros for the identifier allocator.
// Each property is clocked on clk and disabled while arst_n is low.
`ifndef BITMAP_ID_ALLOCATOR_DEFINES_SVH
`define BITMAP_ID_ALLOCATOR_DEFINES_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPL(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) ante |=> cons) else $error(msg);
`else
`define ASSERT_IMPL(label, prop, msg)
`define ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

// File: src/bmid_pkg.sv
package bmid_pkg;

	// default map geometry
	localparam int WORD_BITS_DEF  = 32;
	localparam int WORD_COUNT_DEF = 8;

	// field widths
	localparam int KIND_W   = 2;
	localparam int ID_W     = 8;
	localparam int STATUS_W = 2;

	// request kinds
	localparam logic [KIND_W-1:0] KIND_ALLOC   = 2'd0;
	localparam logic [KIND_W-1:0] KIND_RELEASE = 2'd1;
	localparam logic [KIND_W-1:0] KIND_RESERVE = 2'd2;
	localparam logic [KIND_W-1:0] KIND_CLEAR   = 2'd3;

	// result codes
	localparam logic [STATUS_W-1:0] STAT_OK   = 2'd0;
	localparam logic [STATUS_W-1:0] STAT_NONE = 2'd1;
	localparam logic [STATUS_W-1:0] STAT_BUSY = 2'd2;

endpackage

// File: src/bmid_ram.sv
module bmid_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 8
) (
	input  logic                                  clk,
	input  logic                                  we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                      wdata,
	input  logic                                  re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                      rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// single write port, registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// File: src/bmid_ffz.sv
module bmid_ffz #(
	parameter int WORD_BITS = 32
) (
	input  logic [WORD_BITS-1:0]         word,
	input  logic [WORD_BITS-1:0]         fill,
	output logic                         found,
	output logic [$clog2(WORD_BITS)-1:0] idx,
	output logic [WORD_BITS-1:0]         hot
);

	localparam int BW = $clog2(WORD_BITS);

	logic [WORD_BITS-1:0] free;

	// lowest clear bit: isolate it with x & -x, then encode the one-hot
	always_comb begin
		free  = ~(word | fill);
		hot   = free & (~free + {{(WORD_BITS-1){1'b0}}, 1'b1});
		found = |free;
		idx   = '0;
		for (int i = 0; i < WORD_BITS; i++) begin
			if (hot[i]) begin
				idx = idx | BW'(i);
			end
		end
	end

endmodule

// File: src/bitmap_id_allocator.sv
// Identifier allocator: bitmap of used ids in one word-wide RAM, read-modify-write.
// Release, reserve and clear pass S_RD then S_CHK; the done strobe is registered from S_CHK.
// Allocate: S_RD then S_CHK per scanned word, at most ceil(min(ids,256)/WORD_BITS) words;
// the scan reads one word per RAM read, so its length sets the allocate time.
// Reset (arst_n low, asynchronous) clears per-word valid flags at once: every id is free.
// Results appear for one cycle on done; the receiver cannot stall them.
`include "bitmap_id_allocator_defines.svh"

module bitmap_id_allocator
	import bmid_pkg::*;
#(
	parameter int WORD_BITS  = WORD_BITS_DEF,
	parameter int WORD_COUNT = WORD_COUNT_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  logic [KIND_W-1:0]   kind,
	input  logic [ID_W-1:0]     id,
	output logic                done,
	output logic [STATUS_W-1:0] status,
	output logic [ID_W-1:0]     id_out
);

	localparam int AW        = WORD_COUNT > 1 ? $clog2(WORD_COUNT) : 1;
	localparam int BW        = $clog2(WORD_BITS);
	localparam int CAP       = WORD_BITS * WORD_COUNT;
	localparam int ID_LIMIT  = 1 << ID_W;
	localparam int ALLOC_IDS = CAP < ID_LIMIT ? CAP : ID_LIMIT;
	localparam int ALLOC_WDS = (ALLOC_IDS + WORD_BITS - 1) / WORD_BITS;
	localparam int LAST_BITS = ALLOC_IDS - (ALLOC_WDS - 1) * WORD_BITS;
	localparam int RECIP     = (65536 + WORD_BITS - 1) / WORD_BITS;
	localparam int PW        = ID_W + 17;

	localparam logic [AW-1:0] LAST_WORD = AW'(ALLOC_WDS - 1);
	localparam logic [PW-1:0] RECIP_V   = PW'(RECIP);

	// sequencer states
	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_RD   = 2'd1;
	localparam logic [1:0] S_CHK  = 2'd2;

	logic [1:0]            state_q;
	logic [KIND_W-1:0]     kind_q;
	logic [ID_W-1:0]       id_q;
	logic [AW-1:0]         addr_q;
	logic                  in_range_q;
	logic [WORD_COUNT-1:0] valid_q;
	logic                  done_q;
	logic [STATUS_W-1:0]   status_q;
	logic [ID_W-1:0]       id_out_q;

	logic                  accept;
	logic [PW-1:0]         prod;
	logic [ID_W-1:0]       quot;
	logic                  in_range_c;
	logic                  rd_en;
	logic [AW-1:0]         rd_addr;
	logic [WORD_BITS-1:0]  rd_data;
	logic [WORD_BITS-1:0]  word;
	logic [WORD_BITS-1:0]  fill;
	logic                  ffz_found;
	logic [BW-1:0]         ffz_idx;
	logic [WORD_BITS-1:0]  ffz_hot;
	logic [ID_W-1:0]       base;
	logic [ID_W-1:0]       rem_full;
	logic [WORD_BITS-1:0]  bit_mask;
	logic                  wr_en;
	logic [WORD_BITS-1:0]  wr_data;
	logic                  fin;
	logic [STATUS_W-1:0]   res_status;
	logic [ID_W-1:0]       res_id;
	logic                  scan_next;

	assign accept = start && !busy;
	assign busy   = (state_q != S_IDLE);
	assign done   = done_q;
	assign status = status_q;
	assign id_out = id_out_q;

	// word index by reciprocal multiply, exact for 8-bit ids
	always_comb begin
		prod       = PW'(id_q) * RECIP_V;
		quot       = prod[ID_W+15:16];
		in_range_c = int'(id_q) < CAP;
		rd_addr    = (kind_q == KIND_ALLOC) ? addr_q : quot[AW-1:0];
		rd_en      = (state_q == S_RD) && (kind_q != KIND_CLEAR) &&
			((kind_q == KIND_ALLOC) || in_range_c);
	end

	bmid_ram #(
		.WIDTH (WORD_BITS),
		.DEPTH (WORD_COUNT)
	) u_map (
		.clk   (clk),
		.we    (wr_en),
		.waddr (addr_q),
		.wdata (wr_data),
		.re    (rd_en),
		.raddr (rd_addr),
		.rdata (rd_data)
	);

	// never-written words read as free; ids past the allocate limit read as used
	always_comb begin
		word = valid_q[addr_q] ? rd_data : '0;
		for (int i = 0; i < WORD_BITS; i++) begin
			fill[i] = (addr_q == LAST_WORD) && (i >= LAST_BITS);
		end
	end

	bmid_ffz #(
		.WORD_BITS (WORD_BITS)
	) u_ffz (
		.word  (word),
		.fill  (fill),
		.found (ffz_found),
		.idx   (ffz_idx),
		.hot   (ffz_hot)
	);

	// bit position of a given id inside its word
	always_comb begin
		base     = ID_W'(int'(addr_q) * WORD_BITS);
		rem_full = id_q - base;
		bit_mask = '0;
		bit_mask[rem_full[BW-1:0]] = 1'b1;
	end

	// modify and write back
	always_comb begin
		wr_en      = 1'b0;
		wr_data    = word;
		fin        = 1'b1;
		scan_next  = 1'b0;
		res_status = STAT_OK;
		res_id     = '0;
		case (kind_q)
			KIND_ALLOC: begin
				if (ffz_found) begin
					wr_en   = 1'b1;
					wr_data = word | ffz_hot;
					res_id  = ID_W'(int'(addr_q) * WORD_BITS + int'(ffz_idx));
				end else if (addr_q == LAST_WORD) begin
					res_status = STAT_NONE;
				end else begin
					fin       = 1'b0;
					scan_next = 1'b1;
				end
			end
			KIND_RELEASE: begin
				wr_en   = in_range_q;
				wr_data = word & ~bit_mask;
			end
			KIND_RESERVE: begin
				if (!in_range_q || ((word & bit_mask) != '0)) begin
					res_status = STAT_BUSY;
				end else begin
					wr_en   = 1'b1;
					wr_data = word | bit_mask;
				end
			end
			default: begin
				wr_en = 1'b0;
			end
		endcase
		if (state_q != S_CHK) begin
			wr_en     = 1'b0;
			fin       = 1'b0;
			scan_next = 1'b0;
		end
	end

	// sequencer and control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			valid_q <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= fin;
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_RD;
					end
				end
				S_RD: begin
					state_q <= S_CHK;
				end
				S_CHK: begin
					if (scan_next) begin
						state_q <= S_RD;
					end else begin
						state_q <= S_IDLE;
					end
					if (kind_q == KIND_CLEAR) begin
						valid_q <= '0;
					end else if (wr_en) begin
						valid_q[addr_q] <= 1'b1;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// transaction fields, word address and result registers
	always_ff @(posedge clk) begin
		if (accept) begin
			kind_q <= kind;
			id_q   <= id;
			addr_q <= '0;
		end
		if (state_q == S_RD) begin
			in_range_q <= in_range_c;
			if (kind_q != KIND_ALLOC) begin
				addr_q <= quot[AW-1:0];
			end
		end
		if (scan_next) begin
			addr_q <= addr_q + 1'b1;
		end
		if (fin) begin
			status_q <= res_status;
			id_out_q <= res_id;
		end
	end

	`ASSERT_IMPL(a_done_after_busy, done_q |-> $past(busy), "result without a request in flight")
	`ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted request did not raise busy")
	`ASSERT_IMPL(a_none_only_alloc, done_q && (status_q == STAT_NONE) |-> (kind_q == KIND_ALLOC), "no-free status on a non-allocate request")
	`ASSERT_IMPL(a_id_only_ok, done_q && (id_out_q != '0) |-> (status_q == STAT_OK), "nonzero id with failing status")

endmodule

// File: bench/tb_bitmap_id_allocator.sv
module tb_bitmap_id_allocator;
	import bmid_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	// map geometry seen by the predictor
	localparam int MAP_IDS     = WORD_BITS_DEF * WORD_COUNT_DEF;
	localparam int ALLOC_IDS   = (MAP_IDS < 256) ? MAP_IDS : 256;
	localparam int MAX_CYCLES  = 500000;
	localparam int DRAIN_WAIT  = 2 * WORD_COUNT_DEF + 8;
	localparam int MAX_REPORTS = 50;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [ID_W-1:0]     id_out;
	} alloc_result_t;

	logic                clk;
	logic                arst_n;
	logic                start;
	logic                busy;
	logic [KIND_W-1:0]   kind;
	logic [ID_W-1:0]     id;
	logic                done;
	logic [STATUS_W-1:0] status;
	logic [ID_W-1:0]     id_out;

	// predictor state and bookkeeping
	logic [MAP_IDS-1:0]  used_ids;
	alloc_result_t       pending_results[$];
	int                  err_count;
	int                  cycle_count;
	int                  kind_count[4];
	int                  none_seen;
	int                  busy_seen;
	int                  results_seen;
	bit                  gaps_on;

	bitmap_id_allocator dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.kind   (kind),
		.id     (id),
		.done   (done),
		.status (status),
		.id_out (id_out)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > MAX_CYCLES) begin
			$display("timeout after %0d cycles, %0d results outstanding",
				cycle_count, pending_results.size());
			$display("TEST FAILED");
			$finish;
		end
	end

	task automatic report_mismatch(input string msg);
		err_count++;
		if (err_count <= MAX_REPORTS)
			$display("MISMATCH at %0t: %s", $time, msg);
	endtask

	// expected result of one request; updates the shadow map
	function automatic alloc_result_t predict_request(input logic [KIND_W-1:0] k,
			input logic [ID_W-1:0] i);
		alloc_result_t r;
		r.status = STAT_OK;
		r.id_out = '0;
		case (k)
			KIND_ALLOC: begin
				r.status = STAT_NONE;
				for (int n = 0; n < ALLOC_IDS; n++) begin
					if (!used_ids[n]) begin
						used_ids[n] = 1'b1;
						r.status = STAT_OK;
						r.id_out = ID_W'(n);
						break;
					end
				end
			end
			KIND_RELEASE: begin
				if (int'(i) < MAP_IDS)
					used_ids[i] = 1'b0;
			end
			KIND_RESERVE: begin
				if (int'(i) >= MAP_IDS || used_ids[i])
					r.status = STAT_BUSY;
				else
					used_ids[i] = 1'b1;
			end
			default: begin
				used_ids = '0;
			end
		endcase
		return r;
	endfunction

	// some id that is currently taken, or any id if the map is empty
	function automatic logic [ID_W-1:0] pick_used_id();
		int base;
		int idx;
		base = $urandom_range(0, ALLOC_IDS - 1);
		for (int n = 0; n < ALLOC_IDS; n++) begin
			idx = (base + n) % ALLOC_IDS;
			if (used_ids[idx])
				return ID_W'(idx);
		end
		return ID_W'($urandom_range(0, 255));
	endfunction

	// random input pause; start drops for the whole burst
	task automatic idle_gap();
		if (gaps_on && $urandom_range(0, 3) == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 19)) @(negedge clk);
		end
	endtask

	// one transaction: called at a falling edge, returns at a falling edge
	task automatic send_req(input logic [KIND_W-1:0] k, input logic [ID_W-1:0] i);
		alloc_result_t exp_r;
		kind  <= k;
		id    <= i;
		start <= 1'b1;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		exp_r = predict_request(k, i);
		pending_results.push_back(exp_r);
		kind_count[k]++;
		@(negedge clk);
		idle_gap();
	endtask

	// result checker
	always @(posedge clk) begin
		alloc_result_t exp_r;
		if (arst_n && done) begin
			results_seen++;
			if (status == STAT_NONE)
				none_seen++;
			if (status == STAT_BUSY)
				busy_seen++;
			if (pending_results.size() == 0) begin
				report_mismatch($sformatf("unexpected result status=%0d id_out=%0d",
					status, id_out));
			end else begin
				exp_r = pending_results.pop_front();
				if (status !== exp_r.status)
					report_mismatch($sformatf("status %0d, expected %0d",
						status, exp_r.status));
				if (id_out !== exp_r.id_out)
					report_mismatch($sformatf("id_out %0d, expected %0d",
						id_out, exp_r.id_out));
			end
		end
	end

	// corner cases: lowest-free order, busy reserve, free release, clear
	task automatic test_directed();
		send_req(KIND_ALLOC, 8'hFF);
		send_req(KIND_ALLOC, 8'h00);
		send_req(KIND_ALLOC, 8'h55);
		send_req(KIND_RELEASE, 8'd1);
		send_req(KIND_ALLOC, 8'hAA);
		send_req(KIND_RESERVE, 8'hFF);
		send_req(KIND_RESERVE, 8'hFF);
		send_req(KIND_RESERVE, 8'h00);
		send_req(KIND_RELEASE, 8'hFF);
		send_req(KIND_RESERVE, 8'hFF);
		send_req(KIND_RELEASE, 8'hAA);
		send_req(KIND_RESERVE, 8'h55);
		send_req(KIND_RESERVE, 8'hAA);
		send_req(KIND_RELEASE, 8'h55);
		send_req(KIND_CLEAR, 8'hFF);
		send_req(KIND_ALLOC, 8'hFF);
		send_req(KIND_RESERVE, 8'd1);
		send_req(KIND_RESERVE, 8'd2);
		send_req(KIND_ALLOC, 8'h00);
		send_req(KIND_CLEAR, 8'h00);
		send_req(KIND_ALLOC, 8'hAA);
		send_req(KIND_RELEASE, 8'h00);
	endtask

	// fill the map to exhaustion, punch holes, refill them
	task automatic test_fill_and_drain();
		send_req(KIND_CLEAR, ID_W'($urandom_range(0, 255)));
		send_req(KIND_RESERVE, 8'd31);
		send_req(KIND_RESERVE, 8'd32);
		send_req(KIND_RESERVE, 8'd63);
		send_req(KIND_RESERVE, ID_W'($urandom_range(64, 255)));
		repeat (ALLOC_IDS + 4)
			send_req(KIND_ALLOC, ID_W'($urandom_range(0, 255)));
		repeat (16)
			send_req(KIND_RELEASE, pick_used_id());
		repeat (18)
			send_req(KIND_ALLOC, ID_W'($urandom_range(0, 255)));
	endtask

	// one random request, mix set by alloc_pct
	task automatic send_random(input int alloc_pct);
		int r;
		logic [ID_W-1:0] rid;
		r   = $urandom_range(0, 999);
		rid = ($urandom_range(0, 1) == 0) ? pick_used_id() : ID_W'($urandom_range(0, 255));
		if (r < 8)
			send_req(KIND_CLEAR, rid);
		else if (r < 8 + alloc_pct * 10)
			send_req(KIND_ALLOC, rid);
		else if (r < 8 + alloc_pct * 10 + (1000 - alloc_pct * 10) / 2)
			send_req(KIND_RESERVE, rid);
		else
			send_req(KIND_RELEASE, rid);
	endtask

	// random segments, input gaps on every other one
	task automatic test_random_mix();
		int alloc_pct;
		for (int seg = 0; seg < 6; seg++) begin
			gaps_on   = (seg % 2 == 0);
			alloc_pct = $urandom_range(20, 70);
			repeat (185)
				send_random(alloc_pct);
		end
	endtask

	// closing stretch with no input gaps
	task automatic test_random_back_to_back();
		gaps_on = 1'b0;
		repeat (520)
			send_random($urandom_range(25, 65));
	endtask

	initial begin
		arst_n      = 1'b0;
		start       = 1'b0;
		kind        = KIND_ALLOC;
		id          = '0;
		used_ids    = '0;
		err_count   = 0;
		cycle_count = 0;
		none_seen   = 0;
		busy_seen   = 0;
		results_seen = 0;
		gaps_on     = 1'b1;
		foreach (kind_count[k])
			kind_count[k] = 0;
		repeat (3) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_directed();
		test_fill_and_drain();
		test_random_mix();
		test_random_back_to_back();

		// drain outstanding results
		start <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);

		$display("requests: %0d allocate, %0d release, %0d reserve, %0d clear",
			kind_count[KIND_ALLOC], kind_count[KIND_RELEASE],
			kind_count[KIND_RESERVE], kind_count[KIND_CLEAR]);
		$display("results checked: %0d (%0d map-full, %0d already-taken), %0d mismatches",
			results_seen, none_seen, busy_seen, err_count);
		if (err_count == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
